/* src/assert_macros.svh */
// Assertion macros shared by the RTL. All checks sample on clk_i and are
// masked while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge.
`define GFS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define GFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/gfs_pkg.sv */
package gfs_pkg;

  // Nonterminal table
  localparam int MaxNt    = 32;
  localparam int NtW      = $clog2(MaxNt);
  localparam int CfgW     = 6;

  // Symbol sets: bit 0 epsilon, bit k+1 token k
  localparam int SetBits  = 64;
  localparam int IdW      = 6;
  localparam int ShW      = IdW + 1;

  // Rule symbol store
  localparam int RuleDepth = 256;
  localparam int RuleAw    = $clog2(RuleDepth);
  localparam int RuleCw    = RuleAw + 1;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } op_e;

  typedef enum logic {
    REG_NT_COUNT    = 1'b0,
    REG_TOKEN_COUNT = 1'b1
  } reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DECODE,
    ST_APPLY,
    ST_LHS_RD,
    ST_LHS_WR,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_e;

  typedef struct packed {
    logic [NtW-1:0] lhs;
    logic           empty;
    logic           rend;
    logic           term;
    logic [IdW-1:0] id;
  } entry_t;

  typedef struct packed {
    logic load;
    logic start;
    logic fetch;
    logic decode;
    logic apply;
    logic lhs_rd;
    logic lhs_wr;
    logic restart;
    logic emit_rd;
    logic emit_out;
  } cmd_t;

  typedef struct packed {
    logic ncount_zero;
    logic fill_zero;
    logic rule_done;
    logic pass_end;
    logic pass_dirty;
    logic out_free;
    logic emit_last;
  } sts_t;

endpackage

/* src/gfs_ram.sv */
module gfs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* src/gfs_ctrl.sv */
module gfs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          operation_i,
  output logic          in_ready_o,
  input  gfs_pkg::sts_t sts_i,
  output gfs_pkg::cmd_t cmd_o
);
  import gfs_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (operation_i == OP_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            if (sts_i.ncount_zero) begin
              state_d = ST_IDLE;
            end else if (sts_i.fill_zero) begin
              state_d = ST_EMIT_RD;
            end else begin
              state_d = ST_FETCH;
            end
          end
        end
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = ST_DECODE;
      end
      ST_DECODE: begin
        cmd_o.decode = 1'b1;
        state_d      = ST_APPLY;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = sts_i.rule_done ? ST_LHS_RD : ST_FETCH;
      end
      ST_LHS_RD: begin
        cmd_o.lhs_rd = 1'b1;
        state_d      = ST_LHS_WR;
      end
      ST_LHS_WR: begin
        cmd_o.lhs_wr = 1'b1;
        if (!sts_i.pass_end) begin
          state_d = ST_FETCH;
        end else if (sts_i.pass_dirty) begin
          cmd_o.restart = 1'b1;
          state_d       = ST_FETCH;
        end else begin
          state_d = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        if (sts_i.out_free) begin
          cmd_o.emit_rd = 1'b1;
          state_d       = ST_EMIT_OUT;
        end
      end
      ST_EMIT_OUT: begin
        cmd_o.emit_out = 1'b1;
        state_d        = sts_i.emit_last ? ST_IDLE : ST_EMIT_RD;
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

/* src/gfs_dp.sv */
module gfs_dp (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [gfs_pkg::CfgW-1:0]    cfg_data_i,
  input  logic [gfs_pkg::NtW-1:0]     rule_lhs_i,
  input  logic                        empty_rule_i,
  input  logic                        symbol_is_terminal_i,
  input  logic [gfs_pkg::IdW-1:0]     symbol_id_i,
  input  logic                        rule_end_i,
  input  gfs_pkg::cmd_t               cmd_i,
  output gfs_pkg::sts_t               sts_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gfs_pkg::NtW-1:0]     nonterminal_o,
  output logic [gfs_pkg::SetBits-1:0] first_set_o,
  output logic                        last_o,
  output logic                        store_overflow_o
);
  import gfs_pkg::*;

  // Configuration
  logic [CfgW-1:0]    nt_count_q, tok_count_q;
  logic [CfgW-1:0]    ncount;
  logic [ShW-1:0]     set_w;
  logic [SetBits-1:0] mask;

  // Rule store
  logic [RuleCw-1:0]  fill_q, idx_q, idx_d;
  logic               overflow_q;
  logic               store_full;
  logic               store_we;
  entry_t             wr_ent, ent;

  // Scan state
  logic [NtW-1:0]     lhs_q, lhs_cur;
  logic               lhs_ok_cur, lhs_ok_wr;
  logic               new_rule_q, nullable_q, nullable_d, changed_q;
  logic [SetBits-1:0] acc_q, acc_d;
  logic [MaxNt-1:0]   valid_q;
  logic [NtW-1:0]     nt_q;

  // FIRST table
  logic               tbl_re, tbl_we;
  logic [NtW-1:0]     tbl_raddr, rd_addr_q;
  logic [SetBits-1:0] tbl_rdata, tbl_val, tbl_new, tok_bit;

  // Output register
  logic               out_valid_q, last_q, ovf_out_q;
  logic [NtW-1:0]     nt_out_q;
  logic [SetBits-1:0] set_out_q;
  logic               emit_last;

  // Saturate the nonterminal count and build the set-width mask
  assign ncount = (nt_count_q > CfgW'(MaxNt)) ? CfgW'(MaxNt) : nt_count_q;
  assign set_w  = {1'b0, tok_count_q} + ShW'(1);

  always_comb begin
    for (int b = 0; b < SetBits; b++) begin
      mask[b] = (ShW'(b) < set_w);
    end
  end

  // Store write and read
  assign store_full = (fill_q == RuleCw'(RuleDepth));
  assign store_we   = cmd_i.load && !store_full;
  assign wr_ent     = '{lhs: rule_lhs_i, empty: empty_rule_i, rend: rule_end_i,
                        term: symbol_is_terminal_i, id: symbol_id_i};

  gfs_ram #(
    .Width ($bits(entry_t)),
    .Depth (RuleDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (fill_q[RuleAw-1:0]),
    .wdata_i (wr_ent),
    .re_i    (cmd_i.fetch),
    .raddr_i (idx_q[RuleAw-1:0]),
    .rdata_o (ent)
  );

  // Table read address: symbol in decode, rule lhs at write-back, nt on emit
  always_comb begin
    tbl_raddr = nt_q;
    if (cmd_i.decode) begin
      tbl_raddr = ent.id[NtW-1:0];
    end else if (cmd_i.lhs_rd) begin
      tbl_raddr = lhs_q;
    end
  end
  assign tbl_re  = cmd_i.decode || cmd_i.lhs_rd || cmd_i.emit_rd;
  assign tbl_val = valid_q[rd_addr_q] ? tbl_rdata : '0;

  // A shift by the full set width yields zero: the last token id adds nothing
  assign tok_bit    = SetBits'(1) << ({1'b0, ent.id} + ShW'(1));
  assign lhs_cur    = new_rule_q ? ent.lhs : lhs_q;
  assign lhs_ok_cur = ({1'b0, lhs_cur} < ncount);
  assign lhs_ok_wr  = ({1'b0, lhs_q} < ncount);

  // Fold one symbol into the rule accumulator
  always_comb begin
    acc_d      = acc_q;
    nullable_d = nullable_q;
    if (!ent.empty && nullable_q && lhs_ok_cur) begin
      if (ent.term) begin
        acc_d      = acc_q | (tok_bit & mask);
        nullable_d = 1'b0;
      end else if (ent.id < ncount) begin
        acc_d      = acc_q | (tbl_val & mask & ~SetBits'(1));
        nullable_d = tbl_val[0];
      end else begin
        nullable_d = 1'b0;
      end
    end
  end

  assign idx_d   = idx_q + RuleCw'(1);
  assign tbl_new = tbl_val | acc_q | {{(SetBits-1){1'b0}}, nullable_q};
  assign tbl_we  = cmd_i.lhs_wr && lhs_ok_wr && (tbl_new != tbl_val);

  gfs_ram #(
    .Width (SetBits),
    .Depth (MaxNt)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (lhs_q),
    .wdata_i (tbl_new),
    .re_i    (tbl_re),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  assign emit_last = (({1'b0, nt_q} + CfgW'(1)) == ncount);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nt_count_q  <= CfgW'(MaxNt);
      tok_count_q <= '1;
      fill_q      <= '0;
      overflow_q  <= 1'b0;
      idx_q       <= '0;
      new_rule_q  <= 1'b1;
      nullable_q  <= 1'b1;
      changed_q   <= 1'b0;
      valid_q     <= '0;
      nt_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_NT_COUNT:    nt_count_q  <= cfg_data_i;
          REG_TOKEN_COUNT: tok_count_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (store_we) begin
        fill_q <= fill_q + RuleCw'(1);
      end
      if (cmd_i.load && store_full) begin
        overflow_q <= 1'b1;
      end
      if (cmd_i.start) begin
        valid_q    <= '0;
        idx_q      <= '0;
        changed_q  <= 1'b0;
        nullable_q <= 1'b1;
        new_rule_q <= 1'b1;
        nt_q       <= '0;
      end
      if (cmd_i.apply) begin
        idx_q      <= idx_d;
        nullable_q <= nullable_d;
        new_rule_q <= 1'b0;
      end
      if (cmd_i.lhs_wr) begin
        nullable_q <= 1'b1;
        new_rule_q <= 1'b1;
        if (tbl_we) begin
          valid_q[lhs_q] <= 1'b1;
        end
        if (cmd_i.restart) begin
          idx_q     <= '0;
          changed_q <= 1'b0;
        end else if (tbl_we) begin
          changed_q <= 1'b1;
        end
      end
      if (cmd_i.emit_out) begin
        nt_q        <= nt_q + NtW'(1);
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (tbl_re) begin
      rd_addr_q <= tbl_raddr;
    end
    if (cmd_i.start || cmd_i.lhs_wr) begin
      acc_q <= '0;
    end else if (cmd_i.apply) begin
      acc_q <= acc_d;
    end
    if (cmd_i.apply) begin
      lhs_q <= lhs_cur;
    end
    // Hold the overflow flag with the word so later loads cannot alter it
    if (cmd_i.emit_out) begin
      nt_out_q  <= nt_q;
      set_out_q <= tbl_val;
      last_q    <= emit_last;
      ovf_out_q <= overflow_q;
    end
  end

  assign sts_o = '{
    ncount_zero: (ncount == '0),
    fill_zero:   (fill_q == '0),
    rule_done:   ent.rend || ent.empty || (idx_d == fill_q),
    pass_end:    (idx_q == fill_q),
    pass_dirty:  changed_q || tbl_we,
    out_free:    !out_valid_q || out_ready_i,
    emit_last:   emit_last
  };

  assign out_valid_o      = out_valid_q;
  assign nonterminal_o    = nt_out_q;
  assign first_set_o      = set_out_q;
  assign last_o           = last_q;
  assign store_overflow_o = ovf_out_q;

endmodule

/* src/grammar_first_set_solver.sv */
// Channel   Handshake             Word
// --------  --------------------  ---------------------------------------------------
// in        in_valid_i/in_ready_o operation, rule_lhs, empty_rule, symbol_is_terminal,
//                                 symbol_id, rule_end
// out       out_valid_o/out_ready_i nonterminal, first_set, last, store_overflow
// cfg       cfg_we_i              cfg_index_i selects the register, cfg_data_i value
//
// A load word is taken in idle; words stream in back to back.
// A compute word walks the rule store: every stored entry is fetched, decoded
// and applied, and every rule ends in a read-modify-write of the left-hand set,
// repeated for every pass up to the first pass that changes nothing; the
// registered reads of the store and the FIRST table set these steps.
// Results then leave one per nonterminal, read from the table, last flagged.
// Reset runs no clearing pass; the FIRST table is invalidated at the start of
// every compute. A low out_ready_i holds the emit sequence; input waits until done.
`include "assert_macros.svh"

module grammar_first_set_solver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // configuration writes
  input  logic                        cfg_we_i,
  input  logic                        cfg_index_i,
  input  logic [gfs_pkg::CfgW-1:0]    cfg_data_i,
  // input words
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        operation_i,
  input  logic [gfs_pkg::NtW-1:0]     rule_lhs_i,
  input  logic                        empty_rule_i,
  input  logic                        symbol_is_terminal_i,
  input  logic [gfs_pkg::IdW-1:0]     symbol_id_i,
  input  logic                        rule_end_i,
  // result words
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [gfs_pkg::NtW-1:0]     nonterminal_o,
  output logic [gfs_pkg::SetBits-1:0] first_set_o,
  output logic                        last_o,
  output logic                        store_overflow_o
);
  import gfs_pkg::*;

  // Commands from the sequencer, status back from the datapath
  cmd_t cmd;
  sts_t sts;

  // Sequencer: load words are taken in idle, a compute word walks the store
  // pass by pass and then drains the table into the output register
  gfs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .in_ready_o  (in_ready_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Datapath: rule store, FIRST table with per-entry valid bits, rule
  // accumulator, configuration registers and the output register
  gfs_dp u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .rule_lhs_i           (rule_lhs_i),
    .empty_rule_i         (empty_rule_i),
    .symbol_is_terminal_i (symbol_is_terminal_i),
    .symbol_id_i          (symbol_id_i),
    .rule_end_i           (rule_end_i),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .nonterminal_o        (nonterminal_o),
    .first_set_o          (first_set_o),
    .last_o               (last_o),
    .store_overflow_o     (store_overflow_o)
  );

  // Loading a result must never overwrite one still waiting
  `GFS_ASSERT(a_emit_slot_free, !(cmd.emit_out && out_valid_o), "result overwritten")
  // No input word is taken while results are being emitted
  `GFS_ASSERT(a_no_accept_in_emit, !(cmd.emit_out && in_ready_o), "input taken in emit")
  // A compute with nonterminals to report leaves idle
  `GFS_ASSERT_NEXT(a_busy_after_compute,
    in_valid_i && in_ready_o && (operation_i == OP_COMPUTE) && !sts.ncount_zero,
    !in_ready_o, "compute did not start")

endmodule

/* dv/tb_grammar_first_set_solver.sv */
module tb_grammar_first_set_solver;
  timeunit 1ns;
  timeprecision 1ps;

  import gfs_pkg::*;

  // Hold after the last result before touching the registers or ending the run.
  // A compute under zero nonterminals stays idle, walks no store and emits
  // nothing, so it is done well inside this.
  localparam int SETTLE_CYCLES = 2000;
  // Guard on the whole run, far beyond a full store converging over many passes.
  localparam int RUN_LIMIT_NS  = 20_000_000;

  typedef struct packed {
    logic [NtW-1:0]     nt;
    logic [SetBits-1:0] fset;
    logic               last;
    logic               ovf;
  } first_result_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input is known from time zero
  // ---------------------------------------------------------------------------
  logic                clk_i                = 1'b0;
  logic                rst_ni               = 1'b0;
  logic                cfg_we_i             = 1'b0;
  logic                cfg_index_i          = 1'b0;
  logic [CfgW-1:0]     cfg_data_i           = '0;
  logic                in_valid_i           = 1'b0;
  logic                operation_i          = 1'b0;
  logic [NtW-1:0]      rule_lhs_i           = '0;
  logic                empty_rule_i         = 1'b0;
  logic                symbol_is_terminal_i = 1'b0;
  logic [IdW-1:0]      symbol_id_i          = '0;
  logic                rule_end_i           = 1'b0;
  logic                out_ready_i          = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [NtW-1:0]      nonterminal_o;
  logic [SetBits-1:0]  first_set_o;
  logic                last_o;
  logic                store_overflow_o;

  // ---------------------------------------------------------------------------
  // Predictor state: rule store, fill level, sticky overflow, registers
  // ---------------------------------------------------------------------------
  entry_t              rule_store_model [RuleDepth];
  int unsigned         stored_symbols   = 0;
  bit                  overflow_model   = 1'b0;
  logic [CfgW-1:0]     nt_count_reg     = 6'd32;
  logic [CfgW-1:0]     token_count_reg  = 6'd63;
  logic [SetBits-1:0]  first_tab [MaxNt];
  first_result_t       expected_sets [$];
  first_result_t       head_set;
  int                  mismatch_count   = 0;
  bit                  no_gaps          = 1'b0;
  int                  stall_left       = 0;

  grammar_first_set_solver uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Register values above the table size saturate.
  function automatic int effective_nt();
    return (nt_count_reg > MaxNt) ? MaxNt : int'(nt_count_reg);
  endfunction

  // Set width is token_count + 1 bits, capped at the full word.
  function automatic logic [SetBits-1:0] token_mask();
    int w;
    w = int'(token_count_reg) + 1;
    if (w >= SetBits) return '1;
    return (64'd1 << w) - 64'd1;
  endfunction

  // Fixed-point sweep over the stored rules in store order; queue one result
  // per nonterminal once a pass leaves every set unchanged.
  function automatic void predict_first_sets();
    int                 ncount;
    int unsigned        idx;
    logic [SetBits-1:0] mask;
    logic [SetBits-1:0] bits;
    logic [SetBits-1:0] old;
    logic [NtW-1:0]     lhs;
    entry_t             e;
    bit                 nullable;
    bit                 done;
    bit                 changed;
    first_result_t      res;
    ncount = effective_nt();
    mask   = token_mask();
    foreach (first_tab[i]) first_tab[i] = '0;
    do begin
      changed = 1'b0;
      idx     = 0;
      while (idx < stored_symbols) begin
        // A rule takes the lhs of its first entry; later lhs fields are don't-care.
        lhs      = rule_store_model[idx].lhs;
        nullable = 1'b1;
        done     = 1'b0;
        while (!done && idx < stored_symbols) begin
          e = rule_store_model[idx];
          idx++;
          if (e.rend) done = 1'b1;
          if (e.empty) begin
            done = 1'b1;
            continue;
          end
          if (!nullable || lhs >= ncount) continue;
          bits = '0;
          if (e.term) begin
            // Token 63 would land past the top bit: adds nothing, still stops.
            if (int'(e.id) + 1 < SetBits) bits = (64'd1 << (int'(e.id) + 1)) & mask;
            nullable = 1'b0;
          end else if (e.id < ncount) begin
            bits     = first_tab[e.id] & ~64'd1 & mask;
            nullable = first_tab[e.id][0];
          end else begin
            // Nonterminal beyond the count: empty and not nullable.
            nullable = 1'b0;
          end
          old            = first_tab[lhs];
          first_tab[lhs] = old | bits;
          if (first_tab[lhs] != old) changed = 1'b1;
        end
        // Epsilon only when the whole rule can vanish.
        if (nullable && lhs < ncount) begin
          if (!first_tab[lhs][0]) changed = 1'b1;
          first_tab[lhs][0] = 1'b1;
        end
      end
    end while (changed);
    for (int n = 0; n < ncount; n++) begin
      res.nt   = NtW'(n);
      res.fset = first_tab[n];
      res.last = (n == ncount - 1);
      res.ovf  = overflow_model;
      expected_sets.push_back(res);
    end
  endfunction

  // Mirror one accepted word: a load appends or trips the sticky overflow,
  // a compute queues the expected sets.
  function automatic void apply_word(input op_e op, input logic [NtW-1:0] lhs,
                                     input logic empty, input logic term,
                                     input logic [IdW-1:0] id, input logic rend);
    entry_t e;
    if (op == OP_LOAD) begin
      if (stored_symbols >= RuleDepth) begin
        overflow_model = 1'b1;
      end else begin
        e.lhs   = lhs;
        e.empty = empty;
        e.rend  = rend;
        e.term  = term;
        e.id    = id;
        rule_store_model[stored_symbols] = e;
        stored_symbols++;
      end
    end else begin
      predict_first_sets();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Handshake drivers
  // ---------------------------------------------------------------------------

  // Mostly back to back, sometimes a few cycles, rarely a long hole.
  function automatic int pick_gap();
    int r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Enter and leave on a falling edge. Valid stays high on exit so that a
  // following word with no gap keeps it up without a drop in between.
  task automatic send_word(input op_e op, input logic [NtW-1:0] lhs,
                           input logic empty, input logic term,
                           input logic [IdW-1:0] id, input logic rend);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    operation_i          <= op;
    rule_lhs_i           <= lhs;
    empty_rule_i         <= empty;
    symbol_is_terminal_i <= term;
    symbol_id_i          <= id;
    rule_end_i           <= rend;
    in_valid_i           <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    apply_word(op, lhs, empty, term, id, rend);
    @(negedge clk_i);
  endtask

  task automatic send_symbol(input logic [NtW-1:0] lhs, input logic term,
                             input logic [IdW-1:0] id, input logic rend);
    send_word(OP_LOAD, lhs, 1'b0, term, id, rend);
  endtask

  // Whole empty rule; the other fields are random since they must not matter.
  task automatic send_empty(input logic [NtW-1:0] lhs);
    send_word(OP_LOAD, lhs, 1'b1, 1'($urandom), 6'($urandom), 1'($urandom));
  endtask

  task automatic send_compute();
    send_word(OP_COMPUTE, 5'($urandom), 1'($urandom), 1'($urandom), 6'($urandom),
              1'($urandom));
  endtask

  // Write both counts on consecutive cycles, then drop the enable.
  task automatic set_counts(input logic [CfgW-1:0] nt, input logic [CfgW-1:0] tok);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_NT_COUNT;
    cfg_data_i  <= nt;
    @(negedge clk_i);
    cfg_index_i <= REG_TOKEN_COUNT;
    cfg_data_i  <= tok;
    @(negedge clk_i);
    cfg_we_i        <= 1'b0;
    nt_count_reg    = nt;
    token_count_reg = tok;
  endtask

  // Drop valid, wait for every queued set, then hold for the settle window.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (expected_sets.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Result side: ready high by default, random stalls of the same shape as
  // the sender gaps, none while no_gaps is set.
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else begin
      out_ready_i <= 1'b1;
      if (!no_gaps && $urandom_range(0, 99) < 30) stall_left = pick_gap();
    end
  end

  // Compare every accepted result with the oldest expected set.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_sets.size() == 0) begin
        $error("unexpected result for nonterminal %0d, set %h", nonterminal_o, first_set_o);
        mismatch_count++;
      end else begin
        head_set = expected_sets.pop_front();
        if (nonterminal_o !== head_set.nt) begin
          $error("nonterminal: expected %0d, got %0d", head_set.nt, nonterminal_o);
          mismatch_count++;
        end
        if (first_set_o !== head_set.fset) begin
          $error("first_set: expected %h, got %h", head_set.fset, first_set_o);
          mismatch_count++;
        end
        if (last_o !== head_set.last) begin
          $error("last: expected %0b, got %0b", head_set.last, last_o);
          mismatch_count++;
        end
        if (store_overflow_o !== head_set.ovf) begin
          $error("store_overflow: expected %0b, got %0b", head_set.ovf, store_overflow_o);
          mismatch_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty store under the reset counts: 32 empty sets, overflow clear.
  task automatic test_reset_state();
    send_compute();
  endtask

  // Small grammar over 4 nonterminals and 8-bit sets: nullable prefix,
  // empty rule, token past the set width, top token id, out-of-range
  // nonterminal, left recursion, fully nullable rule, lhs out of range.
  task automatic test_propagation();
    drain_results();
    set_counts(6'd4, 6'd7);
    send_symbol(5'd0, 1'b0, 6'd1, 1'b0);   // 0 -> N1 t2
    send_symbol(5'd0, 1'b1, 6'd2, 1'b1);
    send_empty(5'd1);                      // 1 -> (empty)
    send_symbol(5'd1, 1'b1, 6'd6, 1'b1);   // 1 -> t6, top bit of the set
    send_symbol(5'd2, 1'b1, 6'd7, 1'b1);   // 2 -> t7, just past the set width
    send_symbol(5'd2, 1'b1, 6'd63, 1'b1);  // 2 -> t63, beyond any set
    send_symbol(5'd2, 1'b0, 6'd1, 1'b0);   // 2 -> N1 N1, whole rule nullable
    send_symbol(5'd2, 1'b0, 6'd1, 1'b1);
    send_symbol(5'd3, 1'b0, 6'd1, 1'b0);   // 3 -> N1 N62 t0, scan stops at N62
    send_symbol(5'd3, 1'b0, 6'd62, 1'b0);
    send_symbol(5'd3, 1'b1, 6'd0, 1'b1);
    send_symbol(5'd3, 1'b0, 6'd3, 1'b0);   // 3 -> N3 N0, left recursion
    send_symbol(5'd3, 1'b0, 6'd0, 1'b1);
    send_symbol(5'd31, 1'b1, 6'd0, 1'b1);  // lhs beyond the count: ignored
    send_compute();
  endtask

  // Count extremes: zero nonterminals emits nothing, 63 saturates to 32,
  // a one-bit set keeps only epsilon.
  task automatic test_count_limits();
    drain_results();
    set_counts(6'd0, 6'd63);
    send_compute();
    drain_results();
    set_counts(6'd63, 6'd0);
    send_compute();
    drain_results();
    set_counts(6'd1, 6'd63);
    send_compute();
    drain_results();
    set_counts(6'd32, 6'd62);
    send_compute();
  endtask

  // Leave a rule open at the end of the store; it counts as complete here
  // and keeps growing with the next loads.
  task automatic test_open_rule();
    drain_results();
    set_counts(6'd4, 6'd15);
    send_symbol(5'd2, 1'b1, 6'd5, 1'b0);
    send_compute();
  endtask

  // One random rule; broken leaves off the end mark so it merges with the next.
  task automatic send_random_rule(input bit broken);
    int             ncount;
    int             len;
    int             tok_top;
    logic [NtW-1:0] lhs;
    logic           term;
    logic [IdW-1:0] id;
    ncount  = effective_nt();
    tok_top = (token_count_reg > 62) ? 62 : int'(token_count_reg);
    if (ncount == 0 || $urandom_range(0, 19) == 0) lhs = 5'($urandom_range(0, 31));
    else lhs = 5'($urandom_range(0, ncount - 1));
    len = ($urandom_range(0, 99) < 14) ? 0 : $urandom_range(1, 4);
    if (len == 0) send_empty(lhs);
    for (int k = 0; k < len; k++) begin
      term = ($urandom_range(0, 99) < 45);
      if (term) begin
        if ($urandom_range(0, 9) == 0) id = 6'($urandom_range(0, 62));
        else id = 6'($urandom_range(0, tok_top));
      end else begin
        if (ncount == 0 || $urandom_range(0, 9) == 0) id = 6'($urandom_range(0, 62));
        else id = 6'($urandom_range(0, ncount - 1));
      end
      send_symbol(lhs, term, id, (k == len - 1) && !broken);
    end
  endtask

  // Fill the store with random grammars phase by phase, each phase under a
  // new pair of counts, computing now and then and always at phase end.
  task automatic test_random_grammars();
    logic [CfgW-1:0] nt_pick  [8];
    logic [CfgW-1:0] tok_pick [8];
    int              phase;
    int              r;
    nt_pick  = '{6'd32, 6'd1, 6'd63, 6'd16, 6'd0, 6'd8, 6'd33, 6'd24};
    tok_pick = '{6'd63, 6'd0, 6'd0, 6'd63, 6'd63, 6'd7, 6'd31, 6'd62};
    phase    = 0;
    while (stored_symbols < RuleDepth) begin
      drain_results();
      if (phase < 8) set_counts(nt_pick[phase], tok_pick[phase]);
      else set_counts(6'($urandom_range(1, 32)), 6'($urandom_range(0, 63)));
      no_gaps = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(4, 12)) begin
        r = $urandom_range(0, 99);
        if (r < 6) begin
          // Noise word with every field random.
          send_word(OP_LOAD, 5'($urandom), 1'($urandom), 1'($urandom), 6'($urandom),
                    1'($urandom));
        end else begin
          send_random_rule(r < 14);
        end
        if ($urandom_range(0, 99) < 12) send_compute();
      end
      send_compute();
      phase++;
    end
    no_gaps = 1'b0;
  endtask

  // Store is full: further loads drop and flag overflow on every later result.
  task automatic test_store_overflow();
    drain_results();
    set_counts(6'd32, 6'd63);
    repeat (6) send_symbol(5'($urandom), 1'($urandom), 6'($urandom_range(0, 62)), 1'b1);
    send_compute();
    drain_results();
    set_counts(6'd12, 6'd20);
    send_empty(5'd3);
    send_compute();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    // Hold reset, then release it on a falling edge.
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_propagation();
    test_count_limits();
    test_open_rule();
    test_random_grammars();
    test_store_overflow();
    drain_results();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Stop a hung run.
  initial begin
    #(RUN_LIMIT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
